// ===== hdl/pftp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pftp_pkg: shared types and constants for the true-peak detector
// Field widths, command codes and the front-to-back job record.
// ----------------------------------------------------------------------------
package pftp_pkg;

   localparam int ROWS_DEFAULT   = 15;
   localparam int TAPS_DEFAULT   = 129;
   localparam int FRAMES_DEFAULT = 1024;

   localparam int SAMPLE_W = 24;
   localparam int INDEX_W  = 11;
   localparam int PEAK_W   = 40;
   localparam int FRAME_W  = 10;
   localparam int ACC_W    = 64;
   localparam int PROD_W   = 48;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_COEF   = 1'b1;

   // Job handed from front to back: one completed frame to evaluate.
   typedef struct packed {
      logic [FRAME_W-1:0] frame_index;
      logic               last_in_block;
   } job_type;

endpackage

// ===== hdl/pftp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pftp_front: input classifier and sample history
// Takes coefficient loads and sample pairs, tracks the block position and
// emits one job per completed frame into the job register.
// ----------------------------------------------------------------------------
module pftp_front #(
   parameter int TAPS   = pftp_pkg::TAPS_DEFAULT,
   parameter int FRAMES = pftp_pkg::FRAMES_DEFAULT,
   parameter int POS_W  = $clog2(FRAMES + TAPS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          cmd,
   // job side
   output logic                          job_valid,
   input  logic                          job_ready,
   output pftp_pkg::job_type             job,
   // history write (sample pair) and back busy
   output logic                          hist_we,
   input  logic                          back_busy
);
   localparam int BLOCK = FRAMES + TAPS - 1;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             is_sample;
   logic             fires;
   logic [POS_W-1:0] frame;

   // Hold all intake while a job is pending or the back is busy.
   assign in_ready  = ~back_busy & ~job_valid;
   assign is_sample = in_valid && in_ready && (cmd == pftp_pkg::CMD_SAMPLE);
   assign hist_we   = is_sample;
   assign fires     = is_sample && (pos_ff >= POS_W'(TAPS - 1));
   assign frame     = pos_ff - POS_W'(TAPS - 1);

   // Advance the block position, wrapping at the block length.
   always_comb begin
      pos_in = pos_ff;
      if (is_sample) begin
         if (pos_ff == POS_W'(BLOCK - 1)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         job_valid <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         if (fires) begin
            job_valid <= 1'b1;
         end else if (job_ready) begin
            job_valid <= 1'b0;
         end
      end
   end

   // Job payload.
   always_ff @(posedge clock) begin
      if (fires) begin
         job.frame_index   <= pftp_pkg::FRAME_W'(frame);
         job.last_in_block <= (frame == POS_W'(FRAMES - 1));
      end
   end

   assert property (@(posedge clock) disable iff (reset) fires |=> job_valid)
      else $error("frame without job");
   assert property (@(posedge clock) disable iff (reset) pos_ff < POS_W'(BLOCK))
      else $error("position out of block");
   assert property (@(posedge clock) disable iff (reset) job_valid |-> !in_ready)
      else $error("intake open with pending job");
endmodule

// ===== hdl/pftp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pftp_back: filter bank evaluator
// Walks all rows and taps with one shared multiplier per channel, rounds each
// row magnitude and keeps the running peak; owns coefficient and history RAMs.
// ----------------------------------------------------------------------------
module pftp_back #(
   parameter int ROWS = pftp_pkg::ROWS_DEFAULT,
   parameter int TAPS = pftp_pkg::TAPS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // coefficient load
   input  logic                                 coef_we,
   input  logic [pftp_pkg::INDEX_W-1:0]         coef_index,
   input  logic signed [pftp_pkg::SAMPLE_W-1:0] coef_value,
   // sample write
   input  logic                                 hist_we,
   input  logic signed [pftp_pkg::SAMPLE_W-1:0] left_sample,
   input  logic signed [pftp_pkg::SAMPLE_W-1:0] right_sample,
   // job
   input  logic                                 job_valid,
   output logic                                 job_ready,
   input  pftp_pkg::job_type                    job,
   output logic                                 busy,
   // result
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [pftp_pkg::PEAK_W-1:0]          out_peak,
   output pftp_pkg::job_type                    out_job
);
   localparam int WORDS = ROWS * TAPS;
   localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ADR_W = $clog2(WORDS);
   localparam int SW    = pftp_pkg::SAMPLE_W;
   localparam int AW    = pftp_pkg::ACC_W;
   localparam int PW    = pftp_pkg::PEAK_W;
   localparam logic [AW-1:0] PEAK_MAX = AW'({PW{1'b1}});

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_RUN = 4'b0010, S_DRAIN = 4'b0100, S_OUT = 4'b1000
   } state_type;

   logic signed [SW-1:0] coef_mem [WORDS];
   logic signed [SW-1:0] left_mem [TAPS];
   logic signed [SW-1:0] right_mem [TAPS];
   logic [TAP_W-1:0]     head_ff;   // slot of the oldest sample

   state_type            state_ff;
   logic [TAP_W-1:0]     tap_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [ADR_W-1:0]     cadr_ff;
   logic [TAP_W-1:0]     hadr_ff;
   logic                 rd_v_ff, rd_last_ff;   // read issued, last tap of row
   logic                 mul_v_ff, mul_last_ff;
   logic                 acc_v_ff;              // row sums complete
   logic signed [SW-1:0] w_ff, l_ff, r_ff;
   logic signed [pftp_pkg::PROD_W-1:0] pl_ff, pr_ff;
   logic signed [AW-1:0] accl_ff, accr_ff;
   logic [AW-1:0]        best_ff;
   logic [1:0]           drain_ff;
   logic [AW-1:0]        ml, mr, ql, qr;

   // Write ports of the stores.
   always_ff @(posedge clock) begin
      if (coef_we && coef_index < pftp_pkg::INDEX_W'(WORDS)) begin
         coef_mem[ADR_W'(coef_index)] <= coef_value;
      end
      if (hist_we) begin
         left_mem[head_ff]  <= left_sample;
         right_mem[head_ff] <= right_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else if (hist_we) begin
         head_ff <= (head_ff == TAP_W'(TAPS - 1)) ? '0 : head_ff + TAP_W'(1);
      end
   end

   // Registered reads and registered products.
   always_ff @(posedge clock) begin
      w_ff <= coef_mem[cadr_ff];
      l_ff <= left_mem[hadr_ff];
      r_ff <= right_mem[hadr_ff];
      pl_ff <= pftp_pkg::PROD_W'(w_ff * l_ff);
      pr_ff <= pftp_pkg::PROD_W'(w_ff * r_ff);
   end

   assign job_ready = (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign out_valid = (state_ff == S_OUT);
   assign out_peak  = PW'(best_ff);

   // Round magnitudes of finished row sums and saturate them to the peak width.
   always_comb begin
      ml = accl_ff[AW-1] ? AW'(-accl_ff) : AW'(accl_ff);
      mr = accr_ff[AW-1] ? AW'(-accr_ff) : AW'(accr_ff);
      ql = (ml + AW'(64'd8192)) >> 14;
      qr = (mr + AW'(64'd8192)) >> 14;
      if (ql > PEAK_MAX) ql = PEAK_MAX;
      if (qr > PEAK_MAX) qr = PEAK_MAX;
   end

   // Sequence taps and rows, pipeline read, multiply, accumulate.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rd_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
         acc_v_ff <= 1'b0;
      end else begin
         rd_v_ff    <= 1'b0;
         rd_last_ff <= (tap_ff == TAP_W'(TAPS - 1));
         mul_v_ff   <= rd_v_ff;
         mul_last_ff <= rd_last_ff;
         acc_v_ff   <= mul_v_ff && mul_last_ff;
         case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  out_job  <= job;
                  tap_ff   <= '0;
                  row_ff   <= '0;
                  cadr_ff  <= '0;
                  hadr_ff  <= head_ff;
                  best_ff  <= '0;
                  accl_ff  <= '0;
                  accr_ff  <= '0;
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               rd_v_ff <= 1'b1;
               cadr_ff <= cadr_ff + ADR_W'(1);
               hadr_ff <= (hadr_ff == TAP_W'(TAPS - 1)) ? '0 : hadr_ff + TAP_W'(1);
               if (tap_ff == TAP_W'(TAPS - 1)) begin
                  tap_ff <= '0;
                  if (row_ff == ROW_W'(ROWS - 1)) begin
                     state_ff <= S_DRAIN;
                     drain_ff <= '0;
                  end else begin
                     row_ff <= row_ff + ROW_W'(1);
                  end
               end else begin
                  tap_ff <= tap_ff + TAP_W'(1);
               end
            end
            S_DRAIN: begin
               drain_ff <= drain_ff + 2'd1;
               if (drain_ff == 2'd3) state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         // Accumulate; on row end fold magnitudes into the peak and restart.
         if (acc_v_ff) begin
            if (ql > best_ff && qr <= ql) best_ff <= ql;
            else if (qr > best_ff) best_ff <= qr;
            accl_ff <= mul_v_ff ? AW'(pl_ff) : '0;
            accr_ff <= mul_v_ff ? AW'(pr_ff) : '0;
         end else if (mul_v_ff) begin
            accl_ff <= accl_ff + AW'(pl_ff);
            accr_ff <= accr_ff + AW'(pr_ff);
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> !rd_v_ff && !mul_v_ff && !acc_v_ff)
      else $error("result shown before pipeline drained");
   assert property (@(posedge clock) disable iff (reset) hist_we |-> state_ff == S_IDLE)
      else $error("history written during evaluation");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid && $stable(best_ff))
      else $error("stalled peak changed");
endmodule

// ===== hdl/polyphase_fir_true_peak.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_fir_true_peak: stereo oversampled true-peak detector
// Top level joining the input front, the job register and the filter back.
// ----------------------------------------------------------------------------
// A sample pair that completes a frame hands a job to the back end through
// the job register; the back end then walks all ROWS*TAPS taps, multiplying
// both channels by the two shared multipliers, paced by the single
// coefficient RAM read port, and drains the read, multiply and accumulate
// stages before it shows the result. Intake stalls while a job waits, a frame
// is evaluated or its result waits, and reopens the cycle after the result is
// taken.
module polyphase_fir_true_peak #(
   parameter int ROWS   = pftp_pkg::ROWS_DEFAULT,
   parameter int TAPS   = pftp_pkg::TAPS_DEFAULT,
   parameter int FRAMES = pftp_pkg::FRAMES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,    // cmd
   input  logic [87:0] req_tdata,    // coef_index, coef_value, left_sample, right_sample, 5'b0
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // peak, frame_index, 6'b0
   output logic        rsp_tlast     // last_in_block
);
   logic              job_valid, job_ready, hist_we, busy, coef_we;
   pftp_pkg::job_type job, out_job;
   logic [pftp_pkg::PEAK_W-1:0] peak;

   assign coef_we = req_tvalid && req_tready && (req_tuser == pftp_pkg::CMD_COEF);

   pftp_front #(.TAPS(TAPS), .FRAMES(FRAMES)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .cmd(req_tuser),
      .job_valid, .job_ready, .job, .hist_we, .back_busy(busy)
   );

   pftp_back #(.ROWS(ROWS), .TAPS(TAPS)) u_back (
      .clock, .reset,
      .coef_we, .coef_index(req_tdata[10:0]), .coef_value(req_tdata[34:11]),
      .hist_we, .left_sample(req_tdata[58:35]), .right_sample(req_tdata[82:59]),
      .job_valid, .job_ready, .job, .busy,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_peak(peak), .out_job
   );

   assign rsp_tdata = {6'b0, out_job.frame_index, peak};
   assign rsp_tlast = out_job.last_in_block;
endmodule
